### rtl/core/fbv_pkg.sv
// package: shared constants and types for the frustum box visibility block
`timescale 1ns / 1ps

package fbv_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int COORD_BITS  = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;

  localparam int ELEM_W      = 32;
  localparam int INDEX_W     = 4;
  localparam int MATRIX_N    = 16;
  localparam int NUM_PLANES  = 6;
  localparam int NUM_COEFS   = 4;
  localparam int COEF_W      = ELEM_W + 1;
  localparam int PROD_W      = COEF_W + COORD_BITS;
  localparam int SUM_W       = PROD_W + 2;
  localparam int FRAC_BITS   = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    logic                           is_box;
    logic [INDEX_W-1:0]             idx;
    logic [ELEM_W-1:0]              value;
    logic [2:0][COORD_BITS-1:0]     box_min;
    logic [2:0][COORD_BITS-1:0]     box_max;
  } fbv_item_t;

  typedef struct packed {
    logic      valid;
    fbv_item_t item;
  } fbv_q_t;

endpackage

### rtl/core/fbv_if.sv
// interfaces: request and response channels of the frustum box visibility block
`timescale 1ns / 1ps

interface fbv_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [3:0]  element_index;
  logic signed [31:0] element_value;
  logic signed [31:0] min_x;
  logic signed [31:0] min_y;
  logic signed [31:0] min_z;
  logic signed [31:0] max_x;
  logic signed [31:0] max_y;
  logic signed [31:0] max_z;

  modport source (
    output valid, operation, element_index, element_value,
    output min_x, min_y, min_z, max_x, max_y, max_z,
    input  ready
  );
  modport sink (
    input  valid, operation, element_index, element_value,
    input  min_x, min_y, min_z, max_x, max_y, max_z,
    output ready
  );
endinterface

interface fbv_rsp_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface

### rtl/core/fbv_front.sv
// front end: accepts request words, classifies them and queues them in order
`timescale 1ns / 1ps

module fbv_front (
  input  logic          clk,
  input  logic          rst,
  fbv_req_if.sink       req,
  output fbv_pkg::fbv_q_t head,
  input  logic          pop
);

  fbv_pkg::fbv_item_t             queue_mem [fbv_pkg::QUEUE_DEPTH];
  logic [fbv_pkg::QPTR_W-1:0]     wr_ptr;
  logic [fbv_pkg::QPTR_W-1:0]     rd_ptr;
  logic [fbv_pkg::QCNT_W-1:0]     count;
  logic                           push;
  fbv_pkg::fbv_item_t             item_in;

  assign req.ready = (count < fbv_pkg::QCNT_W'(fbv_pkg::QUEUE_DEPTH));
  assign push      = req.valid && req.ready;

  // classify and trim coordinates to the working width
  always_comb begin
    item_in.is_box     = (req.operation == fbv_pkg::OP_TEST);
    item_in.idx        = req.element_index;
    item_in.value      = req.element_value;
    item_in.box_min[0] = req.min_x[fbv_pkg::COORD_BITS-1:0];
    item_in.box_min[1] = req.min_y[fbv_pkg::COORD_BITS-1:0];
    item_in.box_min[2] = req.min_z[fbv_pkg::COORD_BITS-1:0];
    item_in.box_max[0] = req.max_x[fbv_pkg::COORD_BITS-1:0];
    item_in.box_max[1] = req.max_y[fbv_pkg::COORD_BITS-1:0];
    item_in.box_max[2] = req.max_z[fbv_pkg::COORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head.valid = (count != '0);
  assign head.item  = queue_mem[rd_ptr];

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= fbv_pkg::QCNT_W'(fbv_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("pop from empty queue");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow a push");

endmodule

### rtl/core/fbv_back.sv
// back end: matrix and plane store, p-vertex dot products and result register
`timescale 1ns / 1ps

module fbv_back (
  input  logic            clk,
  input  logic            rst,
  input  fbv_pkg::fbv_q_t head,
  output logic            pop,
  fbv_rsp_if.source       rsp
);

  logic signed [fbv_pkg::ELEM_W-1:0] matrix      [fbv_pkg::MATRIX_N];
  logic signed [fbv_pkg::ELEM_W-1:0] matrix_next [fbv_pkg::MATRIX_N];
  fbv_pkg::coef_t planes      [fbv_pkg::NUM_PLANES][fbv_pkg::NUM_COEFS];
  fbv_pkg::coef_t planes_next [fbv_pkg::NUM_PLANES][fbv_pkg::NUM_COEFS];

  logic signed [fbv_pkg::PROD_W-1:0]     prod [fbv_pkg::NUM_PLANES][3];
  fbv_pkg::coef_t                        s1_w [fbv_pkg::NUM_PLANES];
  logic signed [fbv_pkg::SUM_W-1:0]      s2_a [fbv_pkg::NUM_PLANES];
  logic signed [fbv_pkg::SUM_W-1:0]      s2_b [fbv_pkg::NUM_PLANES];
  logic signed [fbv_pkg::COORD_BITS-1:0] vert [fbv_pkg::NUM_PLANES][3];

  logic s1_valid;
  logic s2_valid;
  logic out_valid;
  logic out_vis;
  logic adv;
  logic load_pop;
  logic box_pop;
  logic all_inside;
  logic signed [fbv_pkg::SUM_W-1:0] total;

  assign adv      = !out_valid || rsp.ready;
  assign load_pop = head.valid && !head.item.is_box;
  assign box_pop  = head.valid && head.item.is_box && adv;
  assign pop      = load_pop || box_pop;

  // planes: row 3 plus or minus row 0, 1, 2 of the matrix after this load
  always_comb begin
    for (int i = 0; i < fbv_pkg::MATRIX_N; i++) begin
      matrix_next[i] = matrix[i];
    end
    if (load_pop) begin
      matrix_next[head.item.idx] = $signed(head.item.value);
    end
    for (int k = 0; k < fbv_pkg::NUM_PLANES; k++) begin
      for (int c = 0; c < fbv_pkg::NUM_COEFS; c++) begin
        if ((k % 2) == 1) begin
          planes_next[k][c] = fbv_pkg::COEF_W'(matrix_next[4'(c * 4 + 3)])
                            - fbv_pkg::COEF_W'(matrix_next[4'(c * 4 + k / 2)]);
        end else begin
          planes_next[k][c] = fbv_pkg::COEF_W'(matrix_next[4'(c * 4 + 3)])
                            + fbv_pkg::COEF_W'(matrix_next[4'(c * 4 + k / 2)]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fbv_pkg::MATRIX_N; i++) begin
        matrix[i] <= '0;
      end
      for (int k = 0; k < fbv_pkg::NUM_PLANES; k++) begin
        for (int c = 0; c < fbv_pkg::NUM_COEFS; c++) begin
          planes[k][c] <= '0;
        end
      end
    end else if (load_pop) begin
      matrix <= matrix_next;
      planes <= planes_next;
    end
  end

  // positive vertex per plane and axis
  always_comb begin
    for (int k = 0; k < fbv_pkg::NUM_PLANES; k++) begin
      for (int c = 0; c < 3; c++) begin
        vert[k][c] = planes[k][c][fbv_pkg::COEF_W-1] ? $signed(head.item.box_min[c])
                                                     : $signed(head.item.box_max[c]);
      end
    end
  end

  // stage 1 products, stage 2 partial sums
  always_ff @(posedge clk) begin
    if (box_pop) begin
      for (int k = 0; k < fbv_pkg::NUM_PLANES; k++) begin
        for (int c = 0; c < 3; c++) begin
          prod[k][c] <= planes[k][c] * vert[k][c];
        end
        s1_w[k] <= planes[k][3];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < fbv_pkg::NUM_PLANES; k++) begin
        s2_a[k] <= fbv_pkg::SUM_W'(prod[k][0]) + fbv_pkg::SUM_W'(prod[k][1]);
        s2_b[k] <= fbv_pkg::SUM_W'(prod[k][2])
                 + (fbv_pkg::SUM_W'(s1_w[k]) <<< fbv_pkg::FRAC_BITS);
      end
    end
  end

  always_comb begin
    all_inside = 1'b1;
    total      = '0;
    for (int k = 0; k < fbv_pkg::NUM_PLANES; k++) begin
      total = s2_a[k] + s2_b[k];
      if (total[fbv_pkg::SUM_W-1]) begin
        all_inside = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_vis <= all_inside;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= box_pop;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.visible = out_vis;

  a_box_enters: assert property (@(posedge clk) disable iff (rst)
    box_pop |=> s1_valid)
    else $error("popped box did not enter the pipe");

  a_pipe_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && adv) |=> s2_valid)
    else $error("stage 1 word lost");

  a_pipe_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(s1_valid) && $stable(s2_valid)))
    else $error("pipe moved while stalled");

endmodule

### rtl/core/frustum_box_visibility.sv
// top level: frustum visibility test for axis-aligned boxes
`timescale 1ns / 1ps
//
// req carries one word per item: operation 0 loads element_index of the
// view-projection matrix (column*4 + row, signed Q16.16) with element_value,
// operation 1 tests the box given by min_x..max_z against the six planes.
// rsp returns one word per box test: visible is 0 when the box lies wholly
// outside some plane. Loads return nothing.
// Words enter a four-deep queue; the back end drains loads at once and
// boxes into a three-register pipe (products, partial sums, result).
// One item per cycle is taken steadily while rsp does not stall; eighteen 33 by COORD_BITS
// multipliers work in parallel on each box.
// A load updates the stored planes as it leaves the queue, so a box after
// it in the stream sees the new matrix.
// When rsp stalls, the result register holds and the pipe stops; req keeps
// being taken until the queue is full.
// Reset clears the matrix to zero, empties the queue and the pipe.
//
module frustum_box_visibility (
  input  logic      clk,
  input  logic      rst,
  fbv_req_if.sink   req,
  fbv_rsp_if.source rsp
);

  fbv_pkg::fbv_q_t head;
  logic            pop;

  fbv_front u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .head (head),
    .pop  (pop)
  );

  fbv_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .rsp  (rsp)
  );

endmodule

### sim/frustum_box_visibility_test.sv
// testbench: matrix loads and box tests through the handshake, checked against a local culling model
`timescale 1ns / 1ps

module frustum_box_visibility_test;

  localparam int          RANDOM_WORDS = 400;
  localparam int          IDLE_LIMIT   = 2000;
  localparam int          TAIL_CYCLES  = 20;
  localparam logic [31:0] Q_ONE        = 32'h0001_0000;
  localparam logic [31:0] Q_HALF       = 32'h0000_8000;
  localparam logic [31:0] Q_MIN        = 32'h8000_0000;
  localparam logic [31:0] Q_MAX        = 32'h7fff_ffff;

  typedef struct packed {
    logic              op;
    logic [3:0]        idx;
    logic [31:0]       val;
    logic [2:0][31:0]  lo;
    logic [2:0][31:0]  hi;
    logic              known;
    logic              vis;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  fbv_req_if req_ch ();
  fbv_rsp_if rsp_ch ();

  frustum_box_visibility DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  logic signed [31:0] proj_matrix [16];
  logic               visible_expected [$];
  logic               want;
  int                 errors     = 0;
  int                 n_results  = 0;
  int                 n_tests    = 0;
  int                 n_loads    = 0;
  int                 n_visible  = 0;
  int                 n_culled   = 0;
  int                 burst_left = 0;
  int                 idle_count = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at result %0d: %s", n_results, msg);
    errors++;
  endtask

  function automatic logic signed [71:0] coord_of(input logic [31:0] v);
    logic signed [71:0] t;
    t = {40'b0, v};
    t = t <<< (72 - fbv_pkg::COORD_BITS);
    return t >>> (72 - fbv_pkg::COORD_BITS);
  endfunction

  // p-vertex test against the six planes of the stored matrix
  function automatic logic sees_box(input logic [2:0][31:0] lo, input logic [2:0][31:0] hi);
    logic signed [31:0] a, b;
    logic signed [32:0] coef;
    logic signed [71:0] cw, plane_sum;
    int                 k, c, r;
    logic               vis;
    vis = 1'b1;
    for (k = 0; k < fbv_pkg::NUM_PLANES; k++) begin
      r = k / 2;
      plane_sum = '0;
      for (c = 0; c < fbv_pkg::NUM_COEFS; c++) begin
        a = proj_matrix[c*4 + 3];
        b = proj_matrix[c*4 + r];
        coef = (k % 2 == 1) ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
        cw = coef;
        if (c == 3) begin
          plane_sum = plane_sum + (cw <<< fbv_pkg::FRAC_BITS);
        end else begin
          plane_sum = plane_sum + cw * coord_of((coef >= 0) ? hi[c] : lo[c]);
        end
      end
      if (plane_sum < 0) vis = 1'b0;
    end
    return vis;
  endfunction

  function automatic stim_row_t load_row(input int idx, input logic [31:0] val);
    stim_row_t w;
    w = '0;
    w.op = fbv_pkg::OP_LOAD;
    w.idx = idx[3:0];
    w.val = val;
    return w;
  endfunction

  function automatic stim_row_t box_row(input logic [31:0] x0, y0, z0, x1, y1, z1,
                                        input logic known, input logic vis);
    stim_row_t w;
    w = '0;
    w.op = fbv_pkg::OP_TEST;
    w.lo = {z0, y0, x0};
    w.hi = {z1, y1, x1};
    w.known = known;
    w.vis = vis;
    return w;
  endfunction

  function automatic logic [31:0] small_q(input int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? Q_MIN : Q_MAX;
      default: return small_q(32'h2_0000);
    endcase
  endfunction

  function automatic stim_row_t rand_box();
    logic [2:0][31:0] lo, hi;
    logic [31:0]      mid, half, t;
    stim_row_t        w;
    int               kind, j;
    kind = $urandom_range(0, 19);
    for (j = 0; j < 3; j++) begin
      if (kind <= 13 || kind >= 18) begin
        mid = small_q(32'h4_0000);
        half = $urandom_range(0, 32'h1_0000);
        lo[j] = mid - half;
        hi[j] = mid + half;
        if (kind >= 18) begin
          t = lo[j];
          lo[j] = hi[j];
          hi[j] = t;
        end
      end else if (kind <= 16) begin
        lo[j] = $urandom;
        hi[j] = $urandom;
      end else begin
        lo[j] = $urandom_range(0, 1) ? Q_MIN : $urandom;
        hi[j] = $urandom_range(0, 1) ? Q_MAX : $urandom;
      end
    end
    w = box_row(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], 1'b0, 1'b0);
    w.idx = 4'($urandom);
    w.val = $urandom;
    return w;
  endfunction

  task automatic send(input stim_row_t w);
    req_ch.valid         <= 1'b1;
    req_ch.operation     <= w.op;
    req_ch.element_index <= w.idx;
    req_ch.element_value <= w.val;
    req_ch.min_x         <= w.lo[0];
    req_ch.min_y         <= w.lo[1];
    req_ch.min_z         <= w.lo[2];
    req_ch.max_x         <= w.hi[0];
    req_ch.max_y         <= w.hi[1];
    req_ch.max_z         <= w.hi[2];
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    if (w.op == fbv_pkg::OP_TEST) begin
      n_tests++;
      visible_expected.push_back(w.known ? w.vis : sees_box(w.lo, w.hi));
    end else begin
      n_loads++;
      proj_matrix[w.idx] = w.val;
    end
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end else begin
      burst_left--;
    end
  endtask

  // receiver stalls on a rotating mask, reshuffled now and then
  initial begin
    logic [12:0] mask;
    int          tick;
    mask = '1;
    tick = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (tick % 97 == 0) begin
        mask = 13'($urandom);
        if ($urandom_range(0, 3) == 0) mask = '1;
        mask[0] = 1'b1;
      end
      rsp_ch.ready <= mask[tick % 13];
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      n_results++;
      if (visible_expected.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = visible_expected.pop_front();
        if (rsp_ch.visible !== want)
          report_mismatch($sformatf("visible %b, expected %b", rsp_ch.visible, want));
        if (want) n_visible++;
        else n_culled++;
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
      idle_count <= 0;
    end else if (idle_count + 1 >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("frustum_box_visibility regression: fail");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    stim_row_t directed_rows [$];
    int        i, sent, shape;
    logic      drained;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.operation = fbv_pkg::OP_LOAD;
    req_ch.element_index = '0;
    req_ch.element_value = '0;
    req_ch.min_x = '0;
    req_ch.min_y = '0;
    req_ch.min_z = '0;
    req_ch.max_x = '0;
    req_ch.max_y = '0;
    req_ch.max_z = '0;
    for (i = 0; i < fbv_pkg::MATRIX_N; i++) proj_matrix[i] = '0;

    // zero matrix: every box visible
    directed_rows.push_back(box_row(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b1, 1'b1));
    directed_rows.push_back(box_row(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b1, 1'b1));
    directed_rows.push_back(box_row(Q_ONE, Q_ONE, Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE, 1'b1, 1'b1));
    // identity frustum
    directed_rows.push_back(load_row(0, Q_ONE));
    directed_rows.push_back(load_row(5, Q_ONE));
    directed_rows.push_back(load_row(10, Q_ONE));
    directed_rows.push_back(load_row(15, Q_ONE));
    directed_rows.push_back(box_row(-Q_HALF, -Q_HALF, -Q_HALF, Q_HALF, Q_HALF, Q_HALF, 1'b0, 1'b0));
    directed_rows.push_back(box_row(2*Q_ONE, 0, 0, 3*Q_ONE, Q_HALF, Q_HALF, 1'b0, 1'b0));
    directed_rows.push_back(box_row(-3*Q_ONE, 0, 0, -2*Q_ONE, Q_HALF, Q_HALF, 1'b0, 1'b0));
    directed_rows.push_back(box_row(0, 0, 2*Q_ONE, Q_HALF, Q_HALF, 3*Q_ONE, 1'b0, 1'b0));
    directed_rows.push_back(box_row(Q_HALF, Q_HALF, Q_HALF, 2*Q_ONE, 2*Q_ONE, 2*Q_ONE, 1'b0, 1'b0));
    directed_rows.push_back(box_row(Q_ONE + Q_HALF, 0, 0, -Q_ONE - Q_HALF, 0, 0, 1'b0, 1'b0));
    directed_rows.push_back(box_row(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b0, 1'b0));
    directed_rows.push_back(box_row(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0, 1'b0));
    // extreme elements
    directed_rows.push_back(load_row(3, Q_MIN));
    directed_rows.push_back(load_row(12, Q_MAX));
    directed_rows.push_back(load_row(7, Q_MAX));
    directed_rows.push_back(load_row(14, Q_MIN));
    directed_rows.push_back(box_row(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b0, 1'b0));
    directed_rows.push_back(box_row(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0, 1'b0));
    directed_rows.push_back(box_row(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b0, 1'b0));
    directed_rows.push_back(load_row(15, 32'h0));
    directed_rows.push_back(box_row(0, 0, 0, 0, 0, 0, 1'b0, 1'b0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) send(directed_rows[i]);

    sent = 0;
    drained = 1'b0;
    while (sent < RANDOM_WORDS) begin
      if (!drained && sent >= RANDOM_WORDS / 2) begin
        // hold off until every result is back
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (visible_expected.size() != 0);
        drained = 1'b1;
      end
      case ($urandom_range(0, 19))
        0: begin
          shape = $urandom_range(0, 1);
          for (i = 0; i < fbv_pkg::MATRIX_N; i++) begin
            if (shape == 1 && i % 5 == 0) send(load_row(i, $urandom_range(32'h8000, 32'h2_0000)));
            else if (shape == 1) send(load_row(i, small_q(32'h2000)));
            else send(load_row(i, rand_elem()));
          end
          sent += fbv_pkg::MATRIX_N;
        end
        1, 2: begin
          send(load_row($urandom_range(0, 15), rand_elem()));
          sent++;
        end
        default: begin
          send(rand_box());
          sent++;
        end
      endcase
    end

    req_ch.valid <= 1'b0;
    while (visible_expected.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (visible_expected.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", visible_expected.size()));

    $display("covered %0d box tests (%0d visible, %0d culled) and %0d matrix loads",
             n_tests, n_visible, n_culled, n_loads);
    $display("sender in bursts, receiver on a rotating stall mask, one full drain mid-run");
    if (errors == 0) begin
      $display("frustum_box_visibility regression: pass");
    end else begin
      $display("frustum_box_visibility regression: fail");
    end
    $finish;
  end

endmodule
